FILE: rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int HDR_BYTES  = 32;
    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int POS_W      = 18;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req_size;
        logic [15:0] free_offset;
    } ffha_in_t;

    typedef struct packed {
        logic [15:0] data_offset;
        logic [1:0]  status;
    } ffha_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } ffha_state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [15:0]      wsize;
        logic             wused;
        logic [IDX_W-1:0] raddr;
    } ffha_mem_ctl_t;

endpackage

FILE: rtl/first_fit_heap_allocator.sv
// flow: after accept, a table read state then a scan state for each block passed over in the walk
// a split then moves each later entry up (shift read, shift write) and writes the remainder
// commands are accepted only while idle, not before the last result strobe; busy stays high through the strobe cycle
// result is on result for one cycle with done high; the receiver cannot stall
// reset clears block count and heap top; table contents need no clearing
module first_fit_heap_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ffha_pkg::ffha_in_t  cmd_in,
    output logic               done,
    output ffha_pkg::ffha_out_t result
);
    import ffha_pkg::*;

    ffha_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [16:0] top_reg, top_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic cmd_reg, cmd_next;
    logic [15:0] req_reg, req_next, off_reg, off_next;
    logic [15:0] fsz_reg, fsz_next;
    ffha_out_t res_reg, res_next;
    ffha_mem_ctl_t ctl;
    logic [15:0] rsize;
    logic rused;
    logic [POS_W-1:0] sum;

    ffha_table u_table (.clk(clk), .ctl(ctl), .rsize(rsize), .rused(rused));

    // shared adder: walks the position, checks the heap end
    always_comb
    begin
        if (state_reg == S_SCAN && i_reg == count_reg)
            sum = POS_W'(top_reg) + POS_W'(HDR_BYTES) + POS_W'(req_reg);
        else
            sum = pos_reg + POS_W'(HDR_BYTES) + POS_W'(rsize);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        k_reg       <= k_next;
        pos_reg     <= pos_next;
        cmd_reg     <= cmd_next;
        req_reg     <= req_next;
        off_reg     <= off_next;
        fsz_reg     <= fsz_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        cmd_next     = cmd_reg;
        req_next     = req_reg;
        off_next     = off_reg;
        fsz_next     = fsz_reg;
        res_next     = res_reg;
        ctl          = '0;
        ctl.raddr    = i_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd_in.cmd;
                    req_next  = cmd_in.req_size;
                    off_next  = cmd_in.free_offset;
                    i_next    = '0;
                    pos_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // read address presented, data arrives next cycle
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (i_reg == count_reg)
                begin
                    if (cmd_reg == CMD_FREE)
                        res_next = '{16'd0, ST_BADFREE};
                    else if (count_reg == CNT_W'(MAX_BLOCKS)
                             || sum > POS_W'(HEAP_BYTES)
                             || POS_W'(top_reg) + POS_W'(HDR_BYTES) >= POS_W'(HEAP_BYTES))
                        res_next = '{16'd0, ST_OOM};
                    else
                    begin
                        ctl.we    = 1'b1;
                        ctl.waddr = count_reg[IDX_W-1:0];
                        ctl.wsize = req_reg;
                        ctl.wused = 1'b1;
                        count_next = count_reg + 1'b1;
                        top_next   = sum[16:0];
                        res_next   = '{16'(top_reg + 17'(HDR_BYTES)), ST_OK};
                    end
                    state_next = S_DONE;
                end
                else if (cmd_reg == CMD_FREE)
                begin
                    if (pos_reg + POS_W'(HDR_BYTES) == POS_W'(off_reg))
                    begin
                        ctl.we    = 1'b1;
                        ctl.waddr = i_reg[IDX_W-1:0];
                        ctl.wsize = rsize;
                        ctl.wused = 1'b0;
                        res_next  = '{16'd0, ST_OK};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next = sum;
                        i_next   = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (!rused && rsize >= req_reg)
                begin
                    res_next = '{16'(pos_reg + POS_W'(HDR_BYTES)), ST_OK};
                    fsz_next = rsize - req_reg;
                    ctl.we    = 1'b1;
                    ctl.waddr = i_reg[IDX_W-1:0];
                    ctl.wused = 1'b1;
                    if (rsize - req_reg > 16'(HDR_BYTES) && count_reg != CNT_W'(MAX_BLOCKS))
                    begin
                        ctl.wsize  = req_reg;
                        k_next     = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        ctl.wsize  = rsize;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    pos_next = sum;
                    i_next   = i_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_SHIFT_RD:
            begin
                ctl.raddr = IDX_W'(k_reg - 1'b1);
                if (k_reg == i_reg + 1'b1)
                begin
                    // the split remainder goes in right after the taken block
                    ctl.we    = 1'b1;
                    ctl.waddr = k_reg[IDX_W-1:0];
                    ctl.wsize = fsz_reg - 16'(HDR_BYTES);
                    ctl.wused = 1'b0;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ctl.we    = 1'b1;
                ctl.waddr = k_reg[IDX_W-1:0];
                ctl.wsize = rsize;
                ctl.wused = rused;
                k_next    = k_reg - 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count over table size");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result");
    a_top_grow: assert property (@(posedge clk) disable iff (!rst_n)
        $past(busy) |-> top_reg >= $past(top_reg))
        else $error("heap top shrank");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command not busy");

endmodule

FILE: rtl/ffha_table.sv
module ffha_table (
    input  logic                   clk,
    input  ffha_pkg::ffha_mem_ctl_t ctl,
    output logic [15:0]            rsize,
    output logic                   rused
);
    import ffha_pkg::*;

    logic [15:0] size_mem [MAX_BLOCKS];
    logic        used_mem [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            size_mem[ctl.waddr] <= ctl.wsize;
            used_mem[ctl.waddr] <= ctl.wused;
        end
        rsize <= size_mem[ctl.raddr];
        rused <= used_mem[ctl.raddr];
    end

endmodule

FILE: bench/ffha_checker.sv
`timescale 1ns / 1ps

module ffha_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  ffha_pkg::ffha_in_t  cmd_in,
    input  logic                done,
    input  ffha_pkg::ffha_out_t result,
    output int                  fail_count
);
    import ffha_pkg::*;

    logic [15:0] blk_len[MAX_BLOCKS];
    logic        blk_taken[MAX_BLOCKS];
    int unsigned n_blocks;
    int unsigned heap_end;
    ffha_out_t   pending_replies[$];
    int          mismatches;

    function automatic ffha_out_t heap_apply(ffha_in_t it);
        ffha_out_t   r;
        int unsigned pos;
        int unsigned sz;
        int unsigned req;
        pos = 0;
        req = it.req_size;
        r.data_offset = '0;
        if (it.cmd == CMD_ALLOC) begin
            for (int i = 0; i < n_blocks; i++) begin
                sz = blk_len[i];
                if (!blk_taken[i] && sz >= req) begin
                    // split only when the leftover can hold a header and some data
                    if (sz - req > HDR_BYTES && n_blocks < MAX_BLOCKS) begin
                        for (int k = n_blocks; k > i + 1; k--) begin
                            blk_len[k]   = blk_len[k-1];
                            blk_taken[k] = blk_taken[k-1];
                        end
                        blk_len[i+1]   = 16'(sz - HDR_BYTES - req);
                        blk_taken[i+1] = 1'b0;
                        blk_len[i]     = 16'(req);
                        n_blocks++;
                    end
                    blk_taken[i] = 1'b1;
                    r.data_offset = 16'(pos + HDR_BYTES);
                    r.status = ST_OK;
                    return r;
                end
                pos += HDR_BYTES + sz;
            end
            if (n_blocks >= MAX_BLOCKS || heap_end + HDR_BYTES + req > HEAP_BYTES ||
                heap_end + HDR_BYTES >= HEAP_BYTES) begin
                r.status = ST_OOM;
                return r;
            end
            blk_len[n_blocks]   = 16'(req);
            blk_taken[n_blocks] = 1'b1;
            n_blocks++;
            r.data_offset = 16'(heap_end + HDR_BYTES);
            r.status = ST_OK;
            heap_end = heap_end + HDR_BYTES + req;
            return r;
        end
        for (int i = 0; i < n_blocks; i++) begin
            if (pos + HDR_BYTES == it.free_offset) begin
                blk_taken[i] = 1'b0;
                r.status = ST_OK;
                return r;
            end
            pos += HDR_BYTES + blk_len[i];
        end
        r.status = ST_BADFREE;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ffha_out_t exp_r;
        if (!rst_n)
        begin
            n_blocks = 0;
            heap_end = 0;
            mismatches = 0;
            pending_replies.delete();
        end
        else
        begin
            if (done)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result beat with nothing expected: data_offset %0d status %0d",
                           result.data_offset, result.status);
                    mismatches++;
                end
                else
                begin
                    exp_r = pending_replies.pop_front();
                    if (result.data_offset !== exp_r.data_offset)
                    begin
                        $error("data_offset expected %0d actual %0d",
                               exp_r.data_offset, result.data_offset);
                        mismatches++;
                    end
                    if (result.status !== exp_r.status)
                    begin
                        $error("status expected %0d actual %0d", exp_r.status, result.status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                pending_replies.push_back(heap_apply(cmd_in));
        end
        fail_count = mismatches + pending_replies.size();
    end

endmodule

FILE: bench/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    ffha_in_t  cmd_in;
    logic      done;
    ffha_out_t result;
    int        fail_count;

    logic [15:0] live_offsets[$];
    logic        cmds_in_flight[$];
    int          idle_cycles;

    first_fit_heap_allocator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd_in (cmd_in),
        .done   (done),
        .result (result)
    );

    ffha_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd_in     (cmd_in),
        .done       (done),
        .result     (result),
        .fail_count (fail_count)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // keep the offsets handed out so frees mostly hit real blocks
    always @(posedge clk)
    begin
        logic c;
        if (rst_n && done && cmds_in_flight.size() > 0)
        begin
            c = cmds_in_flight.pop_front();
            if (c == CMD_ALLOC && result.status == ST_OK)
                live_offsets.push_back(result.data_offset);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAIL first_fit_heap_allocator");
            $finish;
        end
    end

    task automatic issue(input logic c, input logic [15:0] req, input logic [15:0] off);
        int gap;
        int r;
        ffha_in_t it;
        it.cmd = c;
        it.req_size = req;
        it.free_offset = off;
        start <= 1'b1;
        cmd_in <= it;
        do
            @(posedge clk);
        while (!(start && !busy));
        cmds_in_flight.push_back(c);
        r = $urandom_range(99);
        if (r < 60)
            gap = 0;
        else if (r < 94)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 80);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int r;
        int idx;
        logic [15:0] req;
        logic [15:0] off;
        rst_n = 1'b0;
        start = 1'b0;
        cmd_in = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_ALLOC, 16'd0, 16'd0);
        issue(CMD_ALLOC, 16'd100, 16'hFFFF);
        issue(CMD_FREE, 16'hFFFF, 16'd64);
        issue(CMD_ALLOC, 16'd10, 16'd0);      // reuse with split
        issue(CMD_FREE, 16'd0, 16'd64);
        issue(CMD_FREE, 16'd0, 16'd64);       // already free
        issue(CMD_FREE, 16'd0, 16'd1);
        issue(CMD_FREE, 16'd0, 16'hFFFF);
        issue(CMD_FREE, 16'd0, 16'd0);
        issue(CMD_ALLOC, 16'hFFFF, 16'd0);    // past heap end
        issue(CMD_FREE, 16'd0, 16'd32);
        issue(CMD_ALLOC, 16'd0, 16'hFFFF);
        issue(CMD_ALLOC, 16'd40, 16'd0);      // fits without split
        issue(CMD_ALLOC, 16'd10, 16'd0);
        issue(CMD_ALLOC, 16'd10, 16'd0);

        for (int n = 0; n < 1750; n++)
        begin
            if (n == 800)
            begin
                start <= 1'b0;
                wait (cmds_in_flight.size() == 0);
                @(posedge clk);
            end
            r = $urandom_range(99);
            req = 16'($urandom);
            off = 16'($urandom);
            if (r < 45)
            begin
                if (r < 38 && live_offsets.size() > 0)
                begin
                    idx = $urandom_range(live_offsets.size() - 1);
                    off = live_offsets[idx];
                    live_offsets.delete(idx);
                end
                issue(CMD_FREE, req, off);
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 85)
                    req = 16'($urandom_range(0, 200));
                else if (r < 95)
                    req = 16'($urandom_range(200, 4000));
                issue(CMD_ALLOC, req, off);
            end
        end
        start <= 1'b0;
        wait (cmds_in_flight.size() == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("PASS first_fit_heap_allocator");
        else
            $display("FAIL first_fit_heap_allocator");
        $finish;
    end

endmodule
